// File: sv/sct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants for the source character tokenizer: lexer
// modes, event and token codes, character codes and the event bundle that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package sct_pkg;

    // lexer mode
    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_INT,
        M_DECPOT,
        M_DEC,
        M_STRING,
        M_ESC,
        M_SLASH,
        M_COMMENT
    } lex_mode_t;

    // events caused by one source byte
    localparam int MAX_EV   = 5;
    localparam int EV_IDX_W = 3;

    // event kinds
    localparam logic [1:0] EV_CHAR = 2'd0;
    localparam logic [1:0] EV_END  = 2'd1;
    localparam logic [1:0] EV_ERR  = 2'd2;

    // token kinds
    localparam logic [2:0] TK_IDENT  = 3'd0;
    localparam logic [2:0] TK_INT    = 3'd1;
    localparam logic [2:0] TK_DEC    = 3'd2;
    localparam logic [2:0] TK_STRING = 3'd3;
    localparam logic [2:0] TK_OP     = 3'd4;

    // error codes
    localparam logic [1:0] ERR_BAD_ESC    = 2'd0;
    localparam logic [1:0] ERR_SECOND_DOT = 2'd1;
    localparam logic [1:0] ERR_STRAY_BSL  = 2'd2;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    // largest line number shown on a token end
    localparam logic [15:0] LINE_SHOWN_MAX = 16'hFFFF;

    // one event: code holds the token kind or the error code
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [2:0] code;
    } ev_t;

    // all events of one source byte, in order
    typedef struct packed {
        logic [EV_IDX_W-1:0]  count;
        ev_t [MAX_EV-1:0]     ev;
        logic [15:0]          line;
    } bundle_t;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: sv/source_char_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_char_tokenizer
// Byte-serial lexer front end: one source byte in, a run of character,
// token-end and error events out.
// ----------------------------------------------------------------------------
// Usage:
//  - byte channel (byte_valid, byte_stall, char_code, end_of_source) takes a
//    byte a cycle unless stalled; end_of_source closes the open token after it
//  - event channel (event_valid, event_stall, event fields) gives one event
//    word per cycle unless stalled; last_of_run marks the final event of a byte
//  - a byte is decoded in the cycle it is taken; its bundle of 0 to 4 events
//    enters a QUEUE_DEPTH entry queue unless empty, and its first event is on
//    the output in the cycle after the bundle reaches the queue head with the
//    output register free
//  - throughput: one byte per cycle while the queue has room, one event word
//    per cycle out unless stalled; the events of a byte leave one word at a
//    time, and bytes with no events pass without using the queue
//  - byte_stall is high while the queue is full; event_stall holds the
//    current event word and the back end, and the queue then fills up
//  - after an error event every later byte is taken and dropped until reset
//  - reset: lexer idle, line count zero, queue and output empty
// ----------------------------------------------------------------------------
module source_char_tokenizer #(
    parameter int LINE_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  char_code,
    input  logic        end_of_source,
    output logic        event_valid,
    input  logic        event_stall,
    output logic [1:0]  event_kind,
    output logic [7:0]  char_value,
    output logic [2:0]  token_kind,
    output logic [1:0]  error_code,
    output logic [15:0] line_number,
    output logic        last_of_run
);

    sct_pkg::q_status_t q_status;
    sct_pkg::bundle_t   q_push_data;
    sct_pkg::bundle_t   q_head_data;
    logic               q_push;
    logic               q_pop;

    // classify bytes and build event bundles
    sct_front #(
        .LINE_BITS (LINE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .char_code     (char_code),
        .end_of_source (end_of_source),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_push_data   (q_push_data)
    );

    // bundle queue
    sct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head_data),
        .status    (q_status)
    );

    // emit events one word at a time
    sct_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .head_data   (q_head_data),
        .q_pop       (q_pop),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_kind  (event_kind),
        .char_value  (char_value),
        .token_kind  (token_kind),
        .error_code  (error_code),
        .line_number (line_number),
        .last_of_run (last_of_run)
    );

    // an error ends the run of its byte
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && event_kind == sct_pkg::EV_ERR) |-> last_of_run)
        else $error("error event not last of its run");

    // nothing follows a delivered error
    a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && !event_stall && event_kind == sct_pkg::EV_ERR) |=>
        (!event_valid && q_status.empty))
        else $error("event after error");

    // line number only on token ends
    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && event_kind != sct_pkg::EV_END) |-> (line_number == 16'd0))
        else $error("line number on non token end event");

    // queue never pushed while full nor popped while empty
    a_queue_ok: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_status.full) && !(q_pop && q_status.empty))
        else $error("queue overflow or underflow");

endmodule

// File: sv/sct_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_front
// Front end: accepts one source byte per cycle while the queue is not full,
// advances the lexer mode, line count and error halt, and pushes the events
// of that byte, if any, as one bundle into the event queue.
// ----------------------------------------------------------------------------
module sct_front #(
    parameter int LINE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  logic [7:0]          char_code,
    input  logic                end_of_source,
    input  sct_pkg::q_status_t  q_status,
    output logic                q_push,
    output sct_pkg::bundle_t    q_push_data
);

    localparam int LW = (LINE_BITS > 16) ? LINE_BITS : 16;

    sct_pkg::lex_mode_t     lex_mode_reg;
    sct_pkg::lex_mode_t     lex_mode_next;
    logic [LINE_BITS-1:0]   line_count_reg;
    logic [LINE_BITS-1:0]   line_count_next;
    logic                   error_halt_reg;
    logic                   error_halt_next;

    sct_pkg::lex_mode_t     mode_calc;
    sct_pkg::bundle_t       bundle_calc;
    logic                   halt_calc;
    logic                   nl_calc;
    logic                   accept;
    logic [LW-1:0]          line_wide;
    logic [15:0]            line_shown;

    // append one event to a bundle
    function automatic sct_pkg::bundle_t push_ev(
        input sct_pkg::bundle_t b,
        input logic [1:0]       kind,
        input logic [7:0]       ch,
        input logic [2:0]       code
    );
        sct_pkg::bundle_t r;
        r = b;
        r.ev[r.count].kind = kind;
        r.ev[r.count].ch   = ch;
        r.ev[r.count].code = code;
        r.count = r.count + sct_pkg::EV_IDX_W'(1);
        return r;
    endfunction

    // events that close the open token of mode m
    function automatic sct_pkg::bundle_t close_token(
        input sct_pkg::bundle_t   b,
        input sct_pkg::lex_mode_t m
    );
        sct_pkg::bundle_t r;
        r = b;
        case (m)
            sct_pkg::M_IDENT:
                r = push_ev(r, sct_pkg::EV_END, 8'h00, sct_pkg::TK_IDENT);
            sct_pkg::M_INT:
                r = push_ev(r, sct_pkg::EV_END, 8'h00, sct_pkg::TK_INT);
            sct_pkg::M_DEC:
                r = push_ev(r, sct_pkg::EV_END, 8'h00, sct_pkg::TK_DEC);
            sct_pkg::M_STRING, sct_pkg::M_ESC:
                r = push_ev(r, sct_pkg::EV_END, 8'h00, sct_pkg::TK_STRING);
            sct_pkg::M_DECPOT:
                r = push_ev(r, sct_pkg::EV_END, 8'h00, sct_pkg::TK_OP);
            sct_pkg::M_SLASH:
            begin
                r = push_ev(r, sct_pkg::EV_CHAR, sct_pkg::CH_SLASH, 3'd0);
                r = push_ev(r, sct_pkg::EV_END, 8'h00, sct_pkg::TK_OP);
            end
            default:
            begin
                r = b;
            end
        endcase
        return r;
    endfunction

    // single character operators
    function automatic logic is_op(input logic [7:0] c);
        return c inside {8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h3D,
                         8'h2D, 8'h2B, 8'h2A, 8'h3E, 8'h3C, 8'h3B, 8'h2C};
    endfunction

    assign accept     = byte_valid && !q_status.full;
    assign byte_stall = q_status.full;

    // line number as shown on token ends
    always_comb
    begin
        line_wide  = LW'(line_count_reg);
        line_shown = (line_wide > LW'(sct_pkg::LINE_SHOWN_MAX)) ?
                     sct_pkg::LINE_SHOWN_MAX : line_wide[15:0];
    end

    // decode one byte into its events and the mode it leaves
    always_comb
    begin
        logic       done;
        logic       nl;
        logic       esc_ok;
        logic [7:0] esc_char;

        bundle_calc      = '0;
        bundle_calc.line = line_shown;
        mode_calc        = lex_mode_reg;
        halt_calc        = 1'b0;
        nl_calc          = 1'b0;
        done             = 1'b0;
        esc_ok           = 1'b1;
        esc_char         = 8'h00;
        nl = (char_code == sct_pkg::CH_LF) || (char_code == sct_pkg::CH_CR);

        if (!error_halt_reg)
        begin
            // escape, comment and held slash come first
            if (mode_calc == sct_pkg::M_ESC)
            begin
                done = 1'b1;
                case (char_code)
                    sct_pkg::CH_N:      esc_char = sct_pkg::CH_LF;
                    sct_pkg::CH_T:      esc_char = sct_pkg::CH_TAB;
                    sct_pkg::CH_R:      esc_char = sct_pkg::CH_CR;
                    sct_pkg::CH_BSLASH: esc_char = sct_pkg::CH_BSLASH;
                    default:            esc_ok   = 1'b0;
                endcase
                if (esc_ok)
                begin
                    bundle_calc = push_ev(bundle_calc, sct_pkg::EV_CHAR, esc_char, 3'd0);
                    mode_calc   = sct_pkg::M_STRING;
                end
                else
                begin
                    bundle_calc = push_ev(bundle_calc, sct_pkg::EV_ERR, 8'h00,
                                          {1'b0, sct_pkg::ERR_BAD_ESC});
                    halt_calc   = 1'b1;
                end
            end
            else if (mode_calc == sct_pkg::M_COMMENT)
            begin
                done = 1'b1;
                if (nl)
                begin
                    nl_calc   = 1'b1;
                    mode_calc = sct_pkg::M_IDLE;
                end
            end
            else if (mode_calc == sct_pkg::M_SLASH)
            begin
                if (char_code == sct_pkg::CH_SLASH)
                begin
                    mode_calc = sct_pkg::M_COMMENT;
                    done      = 1'b1;
                end
                else
                begin
                    bundle_calc = close_token(bundle_calc, mode_calc);
                    mode_calc   = sct_pkg::M_IDLE;
                end
            end

            // inside a string
            if (!done && mode_calc == sct_pkg::M_STRING)
            begin
                done = 1'b1;
                if (char_code == sct_pkg::CH_DQUOTE || char_code == sct_pkg::CH_SQUOTE)
                begin
                    bundle_calc = close_token(bundle_calc, mode_calc);
                    mode_calc   = sct_pkg::M_IDLE;
                end
                else if (char_code == sct_pkg::CH_BSLASH)
                begin
                    mode_calc = sct_pkg::M_ESC;
                end
                else if (nl)
                begin
                    bundle_calc = close_token(bundle_calc, mode_calc);
                    mode_calc   = sct_pkg::M_IDLE;
                    nl_calc     = 1'b1;
                end
                else
                begin
                    bundle_calc = push_ev(bundle_calc, sct_pkg::EV_CHAR, char_code, 3'd0);
                end
            end

            // byte classes outside strings
            if (!done)
            begin
                if (char_code inside {[sct_pkg::CH_ZERO:sct_pkg::CH_NINE]})
                begin
                    if (mode_calc == sct_pkg::M_IDLE)
                        mode_calc = sct_pkg::M_INT;
                    else if (mode_calc == sct_pkg::M_DECPOT)
                        mode_calc = sct_pkg::M_DEC;
                    bundle_calc = push_ev(bundle_calc, sct_pkg::EV_CHAR, char_code, 3'd0);
                end
                else if (char_code == sct_pkg::CH_DOT)
                begin
                    if (mode_calc == sct_pkg::M_IDLE)
                    begin
                        mode_calc   = sct_pkg::M_DECPOT;
                        bundle_calc = push_ev(bundle_calc, sct_pkg::EV_CHAR, char_code, 3'd0);
                    end
                    else if (mode_calc == sct_pkg::M_INT)
                    begin
                        mode_calc   = sct_pkg::M_DEC;
                        bundle_calc = push_ev(bundle_calc, sct_pkg::EV_CHAR, char_code, 3'd0);
                    end
                    else if (mode_calc == sct_pkg::M_DEC)
                    begin
                        bundle_calc = push_ev(bundle_calc, sct_pkg::EV_ERR, 8'h00,
                                              {1'b0, sct_pkg::ERR_SECOND_DOT});
                        halt_calc   = 1'b1;
                    end
                    else
                    begin
                        bundle_calc = close_token(bundle_calc, mode_calc);
                        mode_calc   = sct_pkg::M_IDLE;
                        bundle_calc = push_ev(bundle_calc, sct_pkg::EV_CHAR, char_code, 3'd0);
                        bundle_calc = push_ev(bundle_calc, sct_pkg::EV_END, 8'h00,
                                              sct_pkg::TK_OP);
                    end
                end
                else if (is_op(char_code))
                begin
                    bundle_calc = close_token(bundle_calc, mode_calc);
                    mode_calc   = sct_pkg::M_IDLE;
                    bundle_calc = push_ev(bundle_calc, sct_pkg::EV_CHAR, char_code, 3'd0);
                    bundle_calc = push_ev(bundle_calc, sct_pkg::EV_END, 8'h00, sct_pkg::TK_OP);
                end
                else if (char_code == sct_pkg::CH_SPACE || char_code == sct_pkg::CH_TAB)
                begin
                    bundle_calc = close_token(bundle_calc, mode_calc);
                    mode_calc   = sct_pkg::M_IDLE;
                end
                else if (nl)
                begin
                    bundle_calc = close_token(bundle_calc, mode_calc);
                    mode_calc   = sct_pkg::M_IDLE;
                    nl_calc     = 1'b1;
                end
                else if (char_code == sct_pkg::CH_DQUOTE || char_code == sct_pkg::CH_SQUOTE)
                begin
                    bundle_calc = close_token(bundle_calc, mode_calc);
                    mode_calc   = sct_pkg::M_STRING;
                end
                else if (char_code == sct_pkg::CH_BSLASH)
                begin
                    bundle_calc = push_ev(bundle_calc, sct_pkg::EV_ERR, 8'h00,
                                          {1'b0, sct_pkg::ERR_STRAY_BSL});
                    halt_calc   = 1'b1;
                end
                else if (char_code == sct_pkg::CH_SLASH)
                begin
                    bundle_calc = close_token(bundle_calc, mode_calc);
                    mode_calc   = sct_pkg::M_SLASH;
                end
                else
                begin
                    if (mode_calc != sct_pkg::M_IDENT)
                    begin
                        bundle_calc = close_token(bundle_calc, mode_calc);
                        mode_calc   = sct_pkg::M_IDENT;
                    end
                    bundle_calc = push_ev(bundle_calc, sct_pkg::EV_CHAR, char_code, 3'd0);
                end
            end

            // flush at end of source unless halted
            if (!halt_calc && end_of_source)
            begin
                if (mode_calc != sct_pkg::M_COMMENT)
                    bundle_calc = close_token(bundle_calc, mode_calc);
                mode_calc = sct_pkg::M_IDLE;
            end
        end
    end

    // next state
    always_comb
    begin
        lex_mode_next   = lex_mode_reg;
        line_count_next = line_count_reg;
        error_halt_next = error_halt_reg;
        if (accept)
        begin
            lex_mode_next   = mode_calc;
            error_halt_next = error_halt_reg | halt_calc;
            if (nl_calc && line_count_reg != {LINE_BITS{1'b1}})
                line_count_next = line_count_reg + LINE_BITS'(1);
        end
    end

    // outputs to the queue
    always_comb
    begin
        q_push      = accept && (bundle_calc.count != '0);
        q_push_data = bundle_calc;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_mode_reg   <= sct_pkg::M_IDLE;
            line_count_reg <= '0;
            error_halt_reg <= 1'b0;
        end
        else
        begin
            lex_mode_reg   <= lex_mode_next;
            line_count_reg <= line_count_next;
            error_halt_reg <= error_halt_next;
        end
    end

endmodule

// File: sv/sct_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_queue
// Short first-in first-out queue of event bundles between the front end
// and the back end.
// ----------------------------------------------------------------------------
module sct_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sct_pkg::bundle_t    push_data,
    input  logic                pop,
    output sct_pkg::bundle_t    head_data,
    output sct_pkg::q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sct_pkg::bundle_t   store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // status and head
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_data    = store_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/sct_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_back
// Back end: walks the events of the queue head bundle, one per cycle unless
// stalled, into the output register of the event channel.
// ----------------------------------------------------------------------------
module sct_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sct_pkg::q_status_t  q_status,
    input  sct_pkg::bundle_t    head_data,
    output logic                q_pop,
    output logic                event_valid,
    input  logic                event_stall,
    output logic [1:0]          event_kind,
    output logic [7:0]          char_value,
    output logic [2:0]          token_kind,
    output logic [1:0]          error_code,
    output logic [15:0]         line_number,
    output logic                last_of_run
);

    logic [sct_pkg::EV_IDX_W-1:0]   idx_reg;
    logic [sct_pkg::EV_IDX_W-1:0]   idx_next;
    logic                           valid_reg;
    logic                           valid_next;
    logic [1:0]                     kind_reg;
    logic [7:0]                     char_reg;
    logic [2:0]                     token_reg;
    logic [1:0]                     error_reg;
    logic [15:0]                    line_reg;
    logic                           last_reg;

    logic                           load;
    logic                           last;
    sct_pkg::ev_t                   cur;

    // pick the current event of the head bundle
    always_comb
    begin
        cur   = head_data.ev[idx_reg];
        last  = (idx_reg == head_data.count - sct_pkg::EV_IDX_W'(1));
        load  = (!valid_reg || !event_stall) && !q_status.empty;
        q_pop = load && last;
    end

    // event index and output valid
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && event_stall;
        if (load)
        begin
            idx_next   = last ? '0 : idx_reg + sct_pkg::EV_IDX_W'(1);
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= cur.kind;
            char_reg  <= cur.ch;
            token_reg <= (cur.kind == sct_pkg::EV_END) ? cur.code : 3'd0;
            error_reg <= (cur.kind == sct_pkg::EV_ERR) ? cur.code[1:0] : 2'd0;
            line_reg  <= (cur.kind == sct_pkg::EV_END) ? head_data.line : 16'd0;
            last_reg  <= last;
        end
    end

    assign event_valid = valid_reg;
    assign event_kind  = kind_reg;
    assign char_value  = char_reg;
    assign token_kind  = token_reg;
    assign error_code  = error_reg;
    assign line_number = line_reg;
    assign last_of_run = last_reg;

endmodule
